// ===== hw/rtl/gbk_pkg.sv =====
package gbk_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [7:0] HiFirst   = 8'h81;
  localparam logic [7:0] LoFirst   = 8'h40;
  localparam logic [7:0] CodeVoid  = 8'hff;
  localparam logic [7:0] LoGap     = 8'h7f;
  localparam logic [7:0] LoAbove   = 8'h41;
  localparam logic [14:0] RowCodes = 15'd190;

  localparam logic [5:0] Size16 = 6'd16;
  localparam logic [5:0] Size24 = 6'd24;
  localparam logic [5:0] Size32 = 6'd32;

  localparam logic [7:0] Len16 = 8'd32;
  localparam logic [7:0] Len24 = 8'd72;
  localparam logic [7:0] Len32 = 8'd128;

  typedef enum logic [2:0] {
    CFG_GLYPH_SIZE   = 3'd0,
    CFG_OPAQUE_MODE  = 3'd1,
    CFG_TEXT_COLOR   = 3'd2,
    CFG_BACK_COLOR   = 3'd3,
    CFG_BASE_ADDR_16 = 3'd4,
    CFG_BASE_ADDR_24 = 3'd5,
    CFG_BASE_ADDR_32 = 3'd6
  } cfg_index_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_BYTE  = 1'b1
  } action_t;

  typedef struct packed {
    logic        opaque;
    logic [15:0] text_color;
    logic [15:0] back_color;
  } pix_cfg_t;

  typedef struct packed {
    logic        is_req;
    logic [31:0] base;
    logic [14:0] index;
    logic [7:0]  length;
    logic        blank;
    logic [7:0]  bits;
    logic [15:0] col;
    logic [15:0] row;
    logic [3:0]  count;
  } job_t;

  function automatic logic [7:0] glyph_len(input logic [5:0] size);
    logic [7:0] len;
    case (size)
      Size16:  len = Len16;
      Size24:  len = Len24;
      Size32:  len = Len32;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/gbk_front.sv =====
module gbk_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  input  logic              action,
  input  logic [7:0]        code_high,
  input  logic [7:0]        code_low,
  input  logic [15:0]       origin_x,
  input  logic [15:0]       origin_y,
  input  logic [7:0]        bitmap_byte,
  input  logic              full,
  output logic              push,
  output gbk_pkg::job_t     job,
  output gbk_pkg::pix_cfg_t pix_cfg
);
  import gbk_pkg::*;

  logic [5:0]  glyph_size;
  logic        opaque_mode;
  logic [15:0] text_color;
  logic [15:0] back_color;
  logic [31:0] base_addr_16;
  logic [31:0] base_addr_24;
  logic [31:0] base_addr_32;

  logic [15:0] column_x;
  logic [15:0] top_row;
  logic [4:0]  row_offset;
  logic [7:0]  bytes_taken;
  logic        blank_flag;
  logic        glyph_active;

  logic        accept;
  logic [7:0]  len;
  logic        blank;
  logic [7:0]  hi_off;
  logic [7:0]  lo_off;
  logic [14:0] index;
  logic [31:0] base_sel;
  logic        byte_ok;
  logic [6:0]  size7;
  logic [6:0]  ro7;
  logic        col_end;
  logic [3:0]  nbits;
  logic [7:0]  taken_next;

  assign pix_cfg.opaque     = opaque_mode;
  assign pix_cfg.text_color = text_color;
  assign pix_cfg.back_color = back_color;

  assign accept  = in_valid && !full;
  assign len     = glyph_len(glyph_size);
  assign byte_ok = glyph_active && (len != 8'd0) && (bytes_taken < len);

  always_comb begin
    blank  = (code_high < HiFirst) || (code_low < LoFirst) ||
             (code_low == CodeVoid) || (code_high == CodeVoid);
    hi_off = code_high - HiFirst;
    lo_off = (code_low < LoGap) ? code_low - LoFirst : code_low - LoAbove;
    index  = ({8'd0, hi_off[6:0]} * RowCodes) + {7'd0, lo_off};
    case (glyph_size)
      Size16:  base_sel = base_addr_16;
      Size24:  base_sel = base_addr_24;
      default: base_sel = base_addr_32;
    endcase
  end

  always_comb begin
    size7   = {1'b0, glyph_size};
    ro7     = {2'b00, row_offset};
    col_end = (ro7 + 7'd8) >= size7;
    if (!col_end) begin
      nbits = 4'd8;
    end else if (ro7 >= size7) begin
      nbits = 4'd1;
    end else begin
      nbits = 4'(size7 - ro7);
    end
    taken_next = bytes_taken + 8'd1;
  end

  always_comb begin
    job  = '0;
    push = 1'b0;
    if (action == ACT_START) begin
      push         = accept && (len != 8'd0);
      job.is_req   = 1'b1;
      job.base     = blank ? 32'd0 : base_sel;
      job.index    = blank ? 15'd0 : index;
      job.length   = len;
      job.blank    = blank;
    end else begin
      push      = accept && byte_ok;
      job.bits  = blank_flag ? 8'd0 : bitmap_byte;
      job.col   = column_x;
      job.row   = top_row + {11'd0, row_offset};
      job.count = nbits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_size   <= Size16;
      opaque_mode  <= 1'b0;
      text_color   <= 16'hffff;
      back_color   <= 16'd0;
      base_addr_16 <= 32'd0;
      base_addr_24 <= 32'd0;
      base_addr_32 <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GLYPH_SIZE:   glyph_size   <= cfg_data[5:0];
        CFG_OPAQUE_MODE:  opaque_mode  <= cfg_data[0];
        CFG_TEXT_COLOR:   text_color   <= cfg_data[15:0];
        CFG_BACK_COLOR:   back_color   <= cfg_data[15:0];
        CFG_BASE_ADDR_16: base_addr_16 <= cfg_data;
        CFG_BASE_ADDR_24: base_addr_24 <= cfg_data;
        CFG_BASE_ADDR_32: base_addr_32 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_x     <= 16'd0;
      top_row      <= 16'd0;
      row_offset   <= 5'd0;
      bytes_taken  <= 8'd0;
      blank_flag   <= 1'b0;
      glyph_active <= 1'b0;
    end else if (accept) begin
      if (action == ACT_START) begin
        if (len == 8'd0) begin
          glyph_active <= 1'b0;
        end else begin
          column_x     <= origin_x;
          top_row      <= origin_y;
          row_offset   <= 5'd0;
          bytes_taken  <= 8'd0;
          blank_flag   <= blank;
          glyph_active <= 1'b1;
        end
      end else if (byte_ok) begin
        if (col_end) begin
          row_offset <= 5'd0;
          column_x   <= column_x + 16'd1;
        end else begin
          row_offset <= row_offset + 5'd8;
        end
        bytes_taken <= taken_next;
        if (taken_next >= len) begin
          glyph_active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/gbk_queue.sv =====
module gbk_queue #(
  parameter int Depth = gbk_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbk_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output gbk_pkg::job_t head,
  output logic          empty
);
  import gbk_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full  = (fill == CntFull);
  assign empty = (fill == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/gbk_back.sv =====
module gbk_back (
  input  logic              clk,
  input  logic              rst,
  input  gbk_pkg::pix_cfg_t pix_cfg,
  input  gbk_pkg::job_t     head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [31:0]       read_address,
  output logic [7:0]        read_length,
  output logic              blank_glyph,
  output logic [15:0]       pixel_x,
  output logic [15:0]       pixel_y,
  output logic [15:0]       pixel_color,
  output logic              last
);
  import gbk_pkg::*;

  logic        busy;
  job_t        cur;
  logic        can_load;
  logic        emit;
  logic        advance;
  logic        more_set;
  logic        more;
  logic [21:0] scaled;
  logic [31:0] addr;

  always_comb begin
    can_load = !out_valid || !out_stall;
    emit     = cur.is_req || cur.bits[7] || pix_cfg.opaque;
    advance  = busy && (!emit || can_load);
    pop      = !busy && !empty;
    more_set = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if ((4'(i + 1) < cur.count) && cur.bits[6 - i]) begin
        more_set = 1'b1;
      end
    end
    more = pix_cfg.opaque ? (cur.count > 4'd1) : more_set;
    case (cur.length)
      Len16:   scaled = {2'b00, cur.index, 5'd0};
      Len24:   scaled = {1'b0, cur.index, 6'd0} + {4'd0, cur.index, 3'd0};
      default: scaled = {cur.index, 7'd0};
    endcase
    addr = cur.base + {10'd0, scaled};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && (cur.is_req || cur.count == 4'd1)) begin
        busy <= 1'b0;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (advance) begin
      cur.bits  <= {cur.bits[6:0], 1'b0};
      cur.row   <= cur.row + 16'd1;
      cur.count <= cur.count - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      if (cur.is_req) begin
        kind         <= KIND_READ;
        read_address <= addr;
        read_length  <= cur.length;
        blank_glyph  <= cur.blank;
        pixel_x      <= 16'd0;
        pixel_y      <= 16'd0;
        pixel_color  <= 16'd0;
        last         <= 1'b1;
      end else begin
        kind         <= KIND_PIXEL;
        read_address <= 32'd0;
        read_length  <= 8'd0;
        blank_glyph  <= 1'b0;
        pixel_x      <= cur.col;
        pixel_y      <= cur.row;
        pixel_color  <= cur.bits[7] ? pix_cfg.text_color : pix_cfg.back_color;
        last         <= !more;
      end
    end
  end

endmodule

// ===== hw/rtl/gbk_glyph_fetch_and_raster_unit.sv =====
// Channel   Direction  Handshake             Word
// config    in         cfg_write             cfg_index, cfg_data
// input     in         in_valid / in_stall   action, code, origin, bitmap_byte
// output    out        out_valid / out_stall read request or pixel write
//
// The front takes one word per cycle while the job queue has room.
// The back loads a job from the queue, then handles its read request or
// its glyph row bits in turn, one bit at a time, until the job is done.
// Reset is synchronous and clears the queue, glyph state, config registers and the back's busy and valid flags.
// A stall on the output holds the back; the queue keeps the front going.
module gbk_glyph_fetch_and_raster_unit #(
  parameter int QueueDepth = gbk_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  code_high,
  input  logic [7:0]  code_low,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [7:0]  bitmap_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [31:0] read_address,
  output logic [7:0]  read_length,
  output logic        blank_glyph,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [15:0] pixel_color,
  output logic        last
);
  import gbk_pkg::*;

  logic     full;
  logic     empty;
  logic     push;
  logic     pop;
  job_t     job;
  job_t     head;
  pix_cfg_t pix_cfg;

  assign in_stall = full;

  gbk_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .action      (action),
    .code_high   (code_high),
    .code_low    (code_low),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .bitmap_byte (bitmap_byte),
    .full        (full),
    .push        (push),
    .job         (job),
    .pix_cfg     (pix_cfg)
  );

  gbk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  gbk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pix_cfg      (pix_cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .read_address (read_address),
    .read_length  (read_length),
    .blank_glyph  (blank_glyph),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .last         (last)
  );

endmodule
